// ===== design/mf3_pkg.sv =====
package mf3_pkg;

   localparam int MAX_COLS_DEFAULT = 1024;
   localparam int MAX_ROWS_DEFAULT = 4096;
   localparam int ROWS_RESET       = 480;
   localparam int COLS_RESET       = 640;
   localparam int WIN_SIZE         = 9;
   localparam int QUEUE_DEPTH      = 8;
   localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 13;
   localparam int REQ_DATA_W       = 24;
   localparam int RSP_DATA_W       = 48;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_ROWS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_COLS = 2'd1;

   typedef logic [WIN_SIZE-1:0][7:0] win_type;

   // per-pixel info carried down the pipe
   typedef struct packed {
      logic        has_med;
      logic        has_bord;
      logic [11:0] row;
      logic [9:0]  col;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } meta_type;

   // one queue entry: all results of one pixel
   typedef struct packed {
      meta_type   meta;
      logic [7:0] med;
   } entry_type;

   // returns {hi, mid, lo}
   function automatic logic [23:0] sort3(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
      logic [7:0] lo;
      logic [7:0] hi;
      logic [7:0] x;
      logic [7:0] y;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      x  = (hi < c) ? hi : c;
      y  = (hi < c) ? c : hi;
      if (x < lo) begin
         return {y, lo, x};
      end else begin
         return {y, x, lo};
      end
   endfunction

endpackage

// ===== design/mf3_line_buf.sv =====
module mf3_line_buf #(
   parameter int MAX_COLS = mf3_pkg::MAX_COLS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_COLS)-1:0]  rd_addr,
   input  mf3_pkg::meta_type            rd_meta,
   output logic                         win_valid,
   output mf3_pkg::win_type             win,
   output mf3_pkg::meta_type            win_meta
);
   import mf3_pkg::*;

   localparam int COL_W = $clog2(MAX_COLS);

   // entry holds {red of row r-2, red of row r-1}
   logic [15:0]      line_mem [MAX_COLS];
   logic [15:0]      rd_data_ff;
   logic             s1_valid_ff;
   meta_type         s1_meta_ff;
   logic [COL_W-1:0] s1_addr_ff;
   logic             fwd_ff;
   logic             fwd_in;
   logic [15:0]      fwd_data_ff;
   logic [15:0]      line_data;
   logic [15:0]      wr_data;
   win_type          win_ff;
   win_type          win_in;
   logic             win_valid_ff;
   meta_type         win_meta_ff;

   assign line_data = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign wr_data   = {line_data[7:0], s1_meta_ff.red};
   // same column read while the previous beat writes it back
   assign fwd_in    = rd_en && s1_valid_ff && (rd_addr == s1_addr_ff);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
      if (s1_valid_ff) begin
         line_mem[s1_addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      s1_meta_ff  <= rd_meta;
      s1_addr_ff  <= rd_addr;
      fwd_ff      <= fwd_in;
      fwd_data_ff <= wr_data;
      win_meta_ff <= s1_meta_ff;
   end

   always_comb begin
      win_in    = win_ff;
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = line_data[15:8];
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = line_data[7:0];
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = s1_meta_ff.red;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         win_valid_ff <= 1'b0;
         win_ff       <= '0;
      end else begin
         s1_valid_ff  <= rd_en;
         win_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            win_ff <= win_in;
         end
      end
   end

   assign win_valid = win_valid_ff;
   assign win       = win_ff;
   assign win_meta  = win_meta_ff;

endmodule

// ===== design/mf3_median.sv =====
module mf3_median (
   input  logic                clock,
   input  logic                reset,
   input  logic                win_valid,
   input  mf3_pkg::win_type    win,
   input  mf3_pkg::meta_type   win_meta,
   output logic                done,
   output logic                push,
   output mf3_pkg::entry_type  push_entry
);
   import mf3_pkg::*;

   logic            m1_valid_ff;
   meta_type        m1_meta_ff;
   logic [2:0][7:0] lo_ff;
   logic [2:0][7:0] mid_ff;
   logic [2:0][7:0] hi_ff;
   logic [2:0][7:0] lo_in;
   logic [2:0][7:0] mid_in;
   logic [2:0][7:0] hi_in;
   logic            m2_valid_ff;
   meta_type        m2_meta_ff;
   logic [7:0]      lo_max_ff;
   logic [7:0]      mid_med_ff;
   logic [7:0]      hi_min_ff;
   logic [23:0]     s_lo;
   logic [23:0]     s_mid;
   logic [23:0]     s_hi;
   logic [23:0]     s_fin;

   // sort each column of the window
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         {hi_in[j], mid_in[j], lo_in[j]} = sort3(win[j], win[j+3], win[j+6]);
      end
   end

   assign s_lo  = sort3(lo_ff[0], lo_ff[1], lo_ff[2]);
   assign s_mid = sort3(mid_ff[0], mid_ff[1], mid_ff[2]);
   assign s_hi  = sort3(hi_ff[0], hi_ff[1], hi_ff[2]);
   assign s_fin = sort3(lo_max_ff, mid_med_ff, hi_min_ff);

   always_ff @(posedge clock) begin
      m1_meta_ff <= win_meta;
      lo_ff      <= lo_in;
      mid_ff     <= mid_in;
      hi_ff      <= hi_in;
      m2_meta_ff <= m1_meta_ff;
      lo_max_ff  <= s_lo[23:16];
      mid_med_ff <= s_mid[15:8];
      hi_min_ff  <= s_hi[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= win_valid;
         m2_valid_ff <= m1_valid_ff;
      end
   end

   assign done            = m2_valid_ff;
   assign push            = m2_valid_ff && (m2_meta_ff.has_med || m2_meta_ff.has_bord);
   assign push_entry.meta = m2_meta_ff;
   assign push_entry.med  = s_fin[15:8];

endmodule

// ===== design/mf3_out_queue.sv =====
module mf3_out_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  mf3_pkg::entry_type                   push_entry,
   output logic [mf3_pkg::QUEUE_CNT_W-1:0]      count,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mf3_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tlast
);
   import mf3_pkg::*;

   entry_type              queue_mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic                   phase_ff;
   entry_type              head;
   logic                   med_beat;
   logic                   fire;
   logic                   pop;
   logic [11:0]            beat_row;
   logic [9:0]             beat_col;
   logic [7:0]             beat_red;
   logic [7:0]             beat_green;
   logic [7:0]             beat_blue;

   assign head     = queue_mem[rd_ptr_ff];
   assign med_beat = head.meta.has_med && !phase_ff;

   always_comb begin
      if (med_beat) begin
         beat_row   = head.meta.row - 12'd1;
         beat_col   = head.meta.col - 10'd1;
         beat_red   = head.med;
         beat_green = head.med;
         beat_blue  = head.med;
         rsp_tlast  = !head.meta.has_bord;
      end else begin
         beat_row   = head.meta.row;
         beat_col   = head.meta.col;
         beat_red   = head.meta.red;
         beat_green = head.meta.green;
         beat_blue  = head.meta.blue;
         rsp_tlast  = 1'b1;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {2'b00, beat_blue, beat_green, beat_red, beat_col, beat_row};
   assign fire       = rsp_tvalid && rsp_tready;
   assign pop        = fire && rsp_tlast;
   assign count      = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
         // second beat of a two-result pixel
         if (fire) begin
            phase_ff <= !pop;
         end
      end
   end

endmodule

// ===== design/median_filter_3x3_core.sv =====
// path: from its req beat a border pixel passes s1, window, m1, m2 and queue to rsp;
//   an interior median starts at the req beat of the pixel one row and one column later
// throughput: one pixel per cycle while the queue has room; a two-result pixel needs two
//   rsp beats, so the lone rsp port paces it; line buffer: one read, one write a cycle
// reset: positions, window, pipeline and result queue clear, frame size 480 x 640;
//   line buffer contents are not cleared
module median_filter_3x3_core #(
   parameter int MAX_COLS = mf3_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = mf3_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mf3_pkg::REQ_DATA_W-1:0]     req_tdata,   // red_in, green_in, blue_in
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mf3_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // out_row, out_col, red_out,
                                                           // green_out, blue_out, 2'b0
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mf3_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mf3_pkg::*;

   localparam int ROW_W        = $clog2(MAX_ROWS);
   localparam int COL_W        = $clog2(MAX_COLS);
   localparam int ROW_LAST_RST = (ROWS_RESET > MAX_ROWS ? MAX_ROWS : ROWS_RESET) - 1;
   localparam int COL_LAST_RST = (COLS_RESET > MAX_COLS ? MAX_COLS : COLS_RESET) - 1;

   logic [ROW_W-1:0]       row_ff;
   logic [ROW_W-1:0]       row_in;
   logic [COL_W-1:0]       col_ff;
   logic [COL_W-1:0]       col_in;
   logic [ROW_W-1:0]       row_last_ff;
   logic [ROW_W-1:0]       row_last_in;
   logic [COL_W-1:0]       col_last_ff;
   logic [COL_W-1:0]       col_last_in;
   logic [QUEUE_CNT_W-1:0] inflight_ff;
   logic [QUEUE_CNT_W-1:0] inflight_in;
   logic [QUEUE_CNT_W-1:0] queue_count;
   logic [QUEUE_CNT_W:0]   reserved;
   logic [31:0]            rows_v;
   logic [31:0]            cols_v;
   logic [31:0]            rows_last;
   logic [31:0]            cols_last;
   logic [31:0]            row_wide;
   logic [31:0]            col_wide;
   logic                   req_fire;
   logic                   csr_fire;
   meta_type               req_meta;
   logic                   win_valid;
   win_type                win;
   meta_type               win_meta;
   logic                   done;
   logic                   push;
   entry_type              push_entry;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // every in-flight pixel holds a queue slot until it leaves the median pipe
   assign reserved   = {1'b0, queue_count} + {1'b0, inflight_ff};
   assign req_tready = (reserved < (QUEUE_CNT_W+1)'(QUEUE_DEPTH));
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      rows_v    = {{(32-CSR_DATA_W){1'b0}}, csr_data};
      cols_v    = {21'd0, csr_data[10:0]};
      rows_last = (rows_v == 32'd0) ? 32'd0 :
                  (rows_v > 32'(MAX_ROWS)) ? 32'(MAX_ROWS - 1) : rows_v - 32'd1;
      cols_last = (cols_v == 32'd0) ? 32'd0 :
                  (cols_v > 32'(MAX_COLS)) ? 32'(MAX_COLS - 1) : cols_v - 32'd1;
      row_last_in = row_last_ff;
      col_last_in = col_last_ff;
      if (csr_fire && csr_index == REG_FRAME_ROWS) begin
         row_last_in = rows_last[ROW_W-1:0];
      end
      if (csr_fire && csr_index == REG_FRAME_COLS) begin
         col_last_in = cols_last[COL_W-1:0];
      end
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (csr_fire && (csr_index == REG_FRAME_ROWS || csr_index == REG_FRAME_COLS)) begin
         row_in = '0;
         col_in = '0;
      end else if (req_fire) begin
         if (col_ff >= col_last_ff) begin
            col_in = '0;
            row_in = (row_ff >= row_last_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      inflight_in = inflight_ff;
      if (req_fire && !done) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (done && !req_fire) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         row_last_ff <= ROW_W'(ROW_LAST_RST);
         col_last_ff <= COL_W'(COL_LAST_RST);
         inflight_ff <= '0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         row_last_ff <= row_last_in;
         col_last_ff <= col_last_in;
         inflight_ff <= inflight_in;
      end
   end

   assign row_wide = 32'(row_ff);
   assign col_wide = 32'(col_ff);

   always_comb begin
      req_meta.has_med  = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
      req_meta.has_bord = (row_ff == '0) || (col_ff == '0) ||
                          (row_ff >= row_last_ff) || (col_ff >= col_last_ff);
      req_meta.row      = row_wide[11:0];
      req_meta.col      = col_wide[9:0];
      req_meta.red      = req_tdata[7:0];
      req_meta.green    = req_tdata[15:8];
      req_meta.blue     = req_tdata[23:16];
   end

   mf3_line_buf #(
      .MAX_COLS (MAX_COLS)
   ) u_line_buf (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_addr   (col_ff),
      .rd_meta   (req_meta),
      .win_valid (win_valid),
      .win       (win),
      .win_meta  (win_meta)
   );

   mf3_median u_median (
      .clock      (clock),
      .reset      (reset),
      .win_valid  (win_valid),
      .win        (win),
      .win_meta   (win_meta),
      .done       (done),
      .push       (push),
      .push_entry (push_entry)
   );

   mf3_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .count      (queue_count),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== design/mf3_checker.sv =====
module mf3_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mf3_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);
   import mf3_pkg::*;

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp beat right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp beat changed");

   // a non-last beat is a median: its second beat is already queued
   a_second_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("second result of a pixel missing");

   a_median_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         (rsp_tdata[29:22] == rsp_tdata[37:30]) && (rsp_tdata[29:22] == rsp_tdata[45:38]))
      else $error("median beat is not gray");

endmodule

bind median_filter_3x3_core mf3_checker u_mf3_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
